// ----- hw/rtl/jsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Jacobi stencil residual package
// Field widths, configuration register indexes and pipeline stage records.
// ----------------------------------------------------------------------------
package jsr_pkg;

  localparam int SampleW   = 32;
  localparam int SumW      = SampleW + 2;
  localparam int RowW      = 16;
  localparam int OutColW   = 10;
  localparam int ResW      = 63;
  localparam int CfgRowsW  = 16;
  localparam int CfgColsW  = 11;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgGridRows = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgGridCols = 8'd1;

  localparam logic [CfgRowsW-1:0] MinRows = 16'd3;

  // One line buffer column: the row above the incoming sample and the one above that.
  typedef struct packed {
    logic signed [SampleW-1:0] up1;
    logic signed [SampleW-1:0] up2;
  } line_t;

  typedef struct packed {
    logic                      last;
    logic signed [SumW-1:0]    sum;
    logic signed [SampleW-1:0] mid;
    logic [RowW-1:0]           row;
    logic [OutColW-1:0]        col;
  } s1_t;

  typedef struct packed {
    logic                      last;
    logic signed [SampleW-1:0] avg;
    logic [SampleW-1:0]        mag;
    logic [RowW-1:0]           row;
    logic [OutColW-1:0]        col;
  } s2_t;

  typedef struct packed {
    logic                      last;
    logic signed [SampleW-1:0] avg;
    logic [ResW-1:0]           sq;
    logic [RowW-1:0]           row;
    logic [OutColW-1:0]        col;
  } s3_t;

endpackage

// ----- hw/rtl/jsr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jsr_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/jacobi_stencil_residual_unit.sv -----
// ----------------------------------------------------------------------------
// Jacobi five-point stencil with residual
// Streams a row-major grid, emits the averaged interior points and, after the
// last sample, the saturating sum of squared differences.
// ----------------------------------------------------------------------------
// Pipeline: a beat's result is registered in stage one, two and three and then in the output register.
// Throughput: one sample beat per cycle while the output is not stalled; the line buffer
// RAM is written once and read once per cycle, and the square goes through its own stage.
// Reset: grid size returns to 3 by 3, position and residual to zero; the line
// buffer is not cleared, as every column is written before it is read.
// ----------------------------------------------------------------------------
module jacobi_stencil_residual_unit #(
  parameter int MaxCols = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jsr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [jsr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [jsr_pkg::SampleW-1:0]  sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jsr_pkg::SampleW-1:0]  new_value_o,
  output logic [jsr_pkg::RowW-1:0]            out_row_o,
  output logic [jsr_pkg::OutColW-1:0]         out_col_o,
  output logic [jsr_pkg::ResW-1:0]            residual_o,
  output logic                                is_last_o
);

  import jsr_pkg::*;

  localparam int ColW = $clog2(MaxCols);
  localparam int EcW  = (ColW + 1 > CfgColsW) ? ColW + 1 : CfgColsW;

  logic [CfgRowsW-1:0] grid_rows_q, grid_rows_d;
  logic [CfgColsW-1:0] grid_cols_q, grid_cols_d;
  logic                restart;

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;

  logic [CfgRowsW-1:0] eff_rows;
  logic [EcW-1:0]      cols_ext, eff_cols, col_ext;
  logic                interior, grid_end, wrap, accept;

  logic signed [SampleW-1:0] left_q, first_q;
  line_t                     mid_q, rd_line;
  logic [$bits(line_t)-1:0]  rd_data;

  s1_t  s1_q;
  s2_t  s2_q;
  s3_t  s3_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  logic [ResW-1:0]           acc_q, acc_d;
  logic [ResW:0]             acc_sum;
  logic signed [SampleW-1:0] new_value_q;
  logic [RowW-1:0]           out_row_q;
  logic [OutColW-1:0]        out_col_q;
  logic [ResW-1:0]           residual_q;
  logic                      is_last_q;

  logic signed [SumW-1:0]    sum;
  logic signed [SampleW:0]   diff;
  logic signed [SampleW-1:0] diff_sat;
  logic [2*SampleW-1:0]      sq_full;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    restart     = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGridRows: begin
          grid_rows_d = cfg_data_i[CfgRowsW-1:0];
          restart     = 1'b1;
        end
        CfgGridCols: begin
          grid_cols_d = cfg_data_i[CfgColsW-1:0];
          restart     = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Grid position.
  assign eff_rows = (grid_rows_q < MinRows) ? MinRows : grid_rows_q;
  assign cols_ext = EcW'(grid_cols_q);
  assign eff_cols = (cols_ext < EcW'(3)) ? EcW'(3) :
                    ((cols_ext > EcW'(MaxCols)) ? EcW'(MaxCols) : cols_ext);
  assign col_ext  = EcW'(col_q);

  assign accept   = in_valid_i && in_ready_o;
  assign interior = (row_q >= RowW'(2)) && (col_q != '0) &&
                    (col_ext <= eff_cols - EcW'(2));
  assign wrap     = (col_ext >= eff_cols - EcW'(1));
  assign grid_end = (row_q >= eff_rows - CfgRowsW'(1)) && wrap;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (grid_end) begin
        row_d = '0;
        col_d = '0;
      end else if (wrap) begin
        row_d = row_q + RowW'(1);
        col_d = '0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= MinRows;
      grid_cols_q <= CfgColsW'(3);
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

  // Line buffer: the read address runs one column ahead of the next sample.
  jsr_ram #(
    .Width ($bits(line_t)),
    .Depth (MaxCols)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i ({sample_i, mid_q.up1}),
    .raddr_i (ColW'(col_d + ColW'(1))),
    .rdata_o (rd_data)
  );

  assign rd_line = line_t'(rd_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      first_q <= '0;
      mid_q   <= '0;
    end else if (accept) begin
      if (col_q == '0) begin
        first_q <= sample_i;
      end
      if (col_d == '0) begin
        mid_q.up1 <= first_q;
      end else begin
        left_q <= mid_q.up1;
        mid_q  <= rd_line;
      end
    end
  end

  // Pipeline flow control.
  assign adv4       = out_ready_i || !v4_q;
  assign adv3       = adv4 || !v3_q;
  assign adv2       = adv3 || !v2_q;
  assign adv1       = adv2 || !v1_q;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      if (adv1) v1_q <= accept && (interior || grid_end);
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      acc_q <= acc_d;
    end
  end

  // Stage one: neighbour sum.
  assign sum = {{2{left_q[SampleW-1]}}, left_q} +
               {{2{rd_line.up1[SampleW-1]}}, rd_line.up1} +
               {{2{mid_q.up2[SampleW-1]}}, mid_q.up2} +
               {{2{sample_i[SampleW-1]}}, sample_i};

  // Stage two: average, saturated difference and its magnitude.
  assign diff = {s1_q.sum[SumW-1], s1_q.sum[SumW-1:2]} - {s1_q.mid[SampleW-1], s1_q.mid};

  always_comb begin
    if (diff[SampleW] != diff[SampleW-1]) begin
      diff_sat = diff[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      diff_sat = diff[SampleW-1:0];
    end
  end

  // Stage three: square of the magnitude.
  assign sq_full = s2_q.mag * s2_q.mag;

  // Stage four: saturating accumulation.
  assign acc_sum = {1'b0, acc_q} + {1'b0, s3_q.sq};

  always_comb begin
    acc_d = acc_q;
    if (restart) begin
      acc_d = '0;
    end else if (adv4 && v3_q) begin
      if (s3_q.last) begin
        acc_d = '0;
      end else if (acc_sum[ResW]) begin
        acc_d = '1;
      end else begin
        acc_d = acc_sum[ResW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && accept) begin
      s1_q.last <= !interior;
      s1_q.sum  <= sum;
      s1_q.mid  <= mid_q.up1;
      s1_q.row  <= row_q - RowW'(1);
      s1_q.col  <= OutColW'(col_q);
    end
    if (adv2 && v1_q) begin
      s2_q.last <= s1_q.last;
      s2_q.avg  <= s1_q.sum[SumW-1:2];
      s2_q.mag  <= diff_sat[SampleW-1] ? SampleW'(-diff_sat) : SampleW'(diff_sat);
      s2_q.row  <= s1_q.row;
      s2_q.col  <= s1_q.col;
    end
    if (adv3 && v2_q) begin
      s3_q.last <= s2_q.last;
      s3_q.avg  <= s2_q.avg;
      s3_q.sq   <= sq_full[ResW-1:0];
      s3_q.row  <= s2_q.row;
      s3_q.col  <= s2_q.col;
    end
    if (adv4 && v3_q) begin
      is_last_q <= s3_q.last;
      if (s3_q.last) begin
        new_value_q <= '0;
        out_row_q   <= '0;
        out_col_q   <= '0;
        residual_q  <= acc_q;
      end else begin
        new_value_q <= s3_q.avg;
        out_row_q   <= s3_q.row;
        out_col_q   <= s3_q.col;
        residual_q  <= '0;
      end
    end
  end

  assign out_valid_o = v4_q;
  assign new_value_o = new_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign residual_o  = residual_q;
  assign is_last_o   = is_last_q;

  // Checks.
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (col_ext < eff_cols) && (row_q < eff_rows))
    else $error("grid position outside the configured grid");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && grid_end) |=> (row_q == '0) && (col_q == '0))
    else $error("position not cleared after the last beat of the grid");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v1_q && v2_q && v3_q && v4_q && !out_ready_i) |-> !in_ready_o)
    else $error("input beat taken while the pipeline is full and stalled");

endmodule
